### sv/fsw_pkg.sv
// Shared constants, tables, types and codes for the four-shape waveform generator.
`timescale 1ns / 1ps

package fsw_pkg;

   localparam int Steps    = 500;
   localparam int StepW    = $clog2(Steps + 1);
   localparam int FreqW    = 5;
   localparam int ShapeW   = 2;
   localparam int DataW    = 16;
   localparam int ProdW    = 2 * DataW;
   localparam int NumW     = StepW + FreqW;
   localparam int RemBitW  = $clog2(FreqW);
   localparam int CsrIdxW  = 2;
   localparam int SineLast = Steps / 2;
   localparam int SineIdxW = $clog2(SineLast + 1);
   localparam int SineMagW = DataW - 1;
   localparam int RampStep = 65535 / Steps;
   localparam int MaxCode  = 65535;
   localparam real MathPi  = 3.14159265358979323846;
   localparam real StepAngle = 2.0 * MathPi / real'(Steps);

   localparam logic [DataW-1:0] MidCode = 16'h8000;

   localparam logic [ShapeW-1:0] SHAPE_SINE     = 2'd0;
   localparam logic [ShapeW-1:0] SHAPE_SQUARE   = 2'd1;
   localparam logic [ShapeW-1:0] SHAPE_SAW      = 2'd2;
   localparam logic [ShapeW-1:0] SHAPE_TRIANGLE = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_WAVE_SHAPE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FREQ_HZ    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_AMPLITUDE  = 2'd2;

   localparam logic [ShapeW-1:0] ShapeReset = SHAPE_SINE;
   localparam logic [FreqW-1:0]  FreqReset  = 5'd1;
   localparam logic [DataW-1:0]  AmpReset   = 16'hFFFF;

   // period per frequency code; code 0 behaves as 1
   typedef logic [StepW-1:0] period_tab_type [0:(1 << FreqW) - 1];
   localparam period_tab_type PeriodTab = '{
      StepW'(Steps / 1),  StepW'(Steps / 1),  StepW'(Steps / 2),  StepW'(Steps / 3),
      StepW'(Steps / 4),  StepW'(Steps / 5),  StepW'(Steps / 6),  StepW'(Steps / 7),
      StepW'(Steps / 8),  StepW'(Steps / 9),  StepW'(Steps / 10), StepW'(Steps / 11),
      StepW'(Steps / 12), StepW'(Steps / 13), StepW'(Steps / 14), StepW'(Steps / 15),
      StepW'(Steps / 16), StepW'(Steps / 17), StepW'(Steps / 18), StepW'(Steps / 19),
      StepW'(Steps / 20), StepW'(Steps / 21), StepW'(Steps / 22), StepW'(Steps / 23),
      StepW'(Steps / 24), StepW'(Steps / 25), StepW'(Steps / 26), StepW'(Steps / 27),
      StepW'(Steps / 28), StepW'(Steps / 29), StepW'(Steps / 30), StepW'(Steps / 31)
   };

   // sine magnitude over the first half of the frame, rounded half away from zero
   typedef logic [SineMagW-1:0] sine_tab_type [0:SineLast];

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      real          v;
      int           i;
      for (i = 0; i <= SineLast; i++) begin
         if (12 * i == Steps || 12 * i == 5 * Steps) begin
            t[i] = SineMagW'(16384);
         end else if (4 * i == Steps) begin
            t[i] = SineMagW'(32767);
         end else begin
            v    = 32767.0 * $sin(StepAngle * real'(i));
            t[i] = SineMagW'($rtoi(v + 0.5));
         end
      end
      return t;
   endfunction

   localparam sine_tab_type SineTab = build_sine_tab();

   typedef struct packed {
      logic             start;
      logic             divide;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic           done;
      logic [DataW:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NumW-1:0]  num;
      logic [StepW-1:0] den;
   } rem_req_type;

   typedef struct packed {
      logic            done;
      logic [NumW-1:0] rem;
   } rem_rsp_type;

endpackage

### sv/fsw_if.sv
// Request and response channel interfaces of the waveform generator.
`timescale 1ns / 1ps

interface fsw_req_if;
   import fsw_pkg::*;
   logic             valid;
   logic             ready;
   logic [DataW-1:0] gain;
   modport source (output valid, output gain, input ready);
   modport sink (input valid, input gain, output ready);
endinterface

interface fsw_rsp_if;
   import fsw_pkg::*;
   logic             valid;
   logic             ready;
   logic [DataW-1:0] sample;
   logic             cycle_start;
   modport source (output valid, output sample, output cycle_start, input ready);
   modport sink (input valid, input sample, input cycle_start, output ready);
endinterface

### sv/fsw_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module fsw_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  fsw_pkg::rem_req_type rem_req,
   output fsw_pkg::rem_rsp_type rem_rsp
);
   import fsw_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RemBitW-1:0] bit_ff, bit_in;
   logic [NumW-1:0]    rem_ff, rem_in;
   logic [StepW-1:0]   den_ff, den_in;
   logic [NumW-1:0]    trial;

   always_comb begin
      trial   = NumW'(den_ff) << bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (rem_req.start) begin
         rem_in  = rem_req.num;
         den_in  = rem_req.den;
         bit_in  = RemBitW'(FreqW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rem_rsp = '{done: done_ff, rem: rem_ff};

endmodule

### sv/fsw_mul.sv
// Shared 16x16 multiplier with optional floor division by 65535.
`timescale 1ns / 1ps

module fsw_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  fsw_pkg::mul_req_type mul_req,
   output fsw_pkg::mul_rsp_type mul_rsp
);
   import fsw_pkg::*;

   logic             prod_vld_ff, prod_vld_in;
   logic             est_vld_ff, est_vld_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [DataW:0]   est_ff, est_in;
   logic [DataW:0]   res_ff, res_in;
   logic [ProdW:0]   est_sum;
   logic [ProdW:0]   est_scaled;
   logic [ProdW:0]   resid;

   // x/65535 ~ (x + x/65536)/65536, low by at most one
   always_comb begin
      est_sum     = {1'b0, prod_ff} + (ProdW + 1)'(prod_ff >> DataW);
      est_scaled  = {est_ff, {DataW{1'b0}}} - (ProdW + 1)'(est_ff);
      resid       = {1'b0, prod_ff} - est_scaled;
      prod_vld_in = 1'b0;
      est_vld_in  = 1'b0;
      done_in     = 1'b0;
      div_in      = div_ff;
      prod_in     = prod_ff;
      est_in      = est_ff;
      res_in      = res_ff;
      if (mul_req.start) begin
         prod_in     = ProdW'(mul_req.a) * ProdW'(mul_req.b);
         div_in      = mul_req.divide;
         prod_vld_in = 1'b1;
      end
      if (prod_vld_ff) begin
         if (div_ff) begin
            est_in     = est_sum[ProdW:DataW];
            est_vld_in = 1'b1;
         end else begin
            res_in  = prod_ff[DataW:0];
            done_in = 1'b1;
         end
      end
      if (est_vld_ff) begin
         res_in  = (resid >= (ProdW + 1)'(MaxCode)) ? est_ff + 1'b1 : est_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         est_vld_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         est_vld_ff  <= est_vld_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      prod_ff <= prod_in;
      est_ff  <= est_in;
      res_ff  <= res_in;
   end

   assign mul_rsp = '{done: done_ff, result: res_ff};

endmodule

### sv/four_shape_waveform_generator.sv
// Top level of the four-shape waveform generator: registers, sequencer and output stage.
//
// Each request on req_chan carries a 16-bit gain word and produces one response on
// rsp_chan: a 16-bit DAC sample and a cycle_start flag set when the wave phase is zero.
// The block steps through a frame of 500 samples; wave_shape, freq_hz and amplitude are
// written through the csr_ port (csr_we, csr_index, csr_wdata); the user must write them
// only while no request is open, as the block itself does not enforce this. One
// multiplier, which also performs the floor division by 65535, and one restoring
// remainder unit are shared under a sequencer; a request is taken only when the
// sequencer is idle. A request runs through the remainder unit for the phase, then
// through multiplier passes: square needs only the gain pass; sawtooth and triangle
// multiply by frequency, ramp step and amplitude first; sine multiplies step by
// frequency, takes a second remainder pass and a table lookup, then scales by amplitude.
// A new request is taken only once the result of the last one is registered.
// The response sits in an output register; the next request is accepted while it waits.
// If the receiver stalls, the following result is held in the multiplier until the
// output register frees up.
// Reset (synchronous) returns the frame to step 0 and the registers to sine, 1 Hz and
// full-scale amplitude.
`timescale 1ns / 1ps

module four_shape_waveform_generator (
   input  logic                         clock,
   input  logic                         reset,
   fsw_req_if.sink                      req_chan,
   fsw_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [fsw_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fsw_pkg::DataW-1:0]    csr_wdata
);
   import fsw_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PHASE = 4'd1;
   localparam logic [3:0] ST_SHAPE = 4'd2;
   localparam logic [3:0] ST_KMUL  = 4'd3;
   localparam logic [3:0] ST_KREM  = 4'd4;
   localparam logic [3:0] ST_LUT   = 4'd5;
   localparam logic [3:0] ST_SINE  = 4'd6;
   localparam logic [3:0] ST_M1    = 4'd7;
   localparam logic [3:0] ST_M2    = 4'd8;
   localparam logic [3:0] ST_RAW   = 4'd9;
   localparam logic [3:0] ST_SCALE = 4'd10;
   localparam logic [3:0] ST_GAIN  = 4'd11;
   localparam logic [3:0] ST_WB    = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [ShapeW-1:0]   shape_ff, shape_in;
   logic [FreqW-1:0]    freq_ff, freq_in;
   logic [DataW-1:0]    amp_ff, amp_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [StepW-1:0]    ph_ff, ph_in;
   logic [StepW-1:0]    p_ff, p_in;
   logic [DataW-1:0]    gain_ff, gain_in;
   logic [DataW-1:0]    raw_ff, raw_in;
   logic [SineIdxW-1:0] idx_ff, idx_in;
   logic                neg_ff, neg_in;
   logic [DataW-1:0]    sine_ff, sine_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]    sample_ff, sample_in;
   logic                cstart_ff, cstart_in;

   logic                accept;
   logic                load;
   logic [FreqW-1:0]    f_eff;
   logic [StepW-1:0]    half;
   logic [StepW-1:0]    tri_x;
   logic [StepW-1:0]    k_val;
   logic                k_neg;
   logic [SineMagW-1:0] mag;
   logic [DataW+1:0]    raw_wide;
   logic [StepW-1:0]    step_next;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   rem_req_type rem_req;
   rem_rsp_type rem_rsp;

   fsw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   fsw_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign accept               = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sample      = sample_ff;
   assign rsp_chan.cycle_start = cstart_ff;

   always_comb begin
      shape_in = shape_ff;
      freq_in  = freq_ff;
      amp_in   = amp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WAVE_SHAPE: shape_in = csr_wdata[ShapeW-1:0];
            CSR_FREQ_HZ:    freq_in  = csr_wdata[FreqW-1:0];
            CSR_AMPLITUDE:  amp_in   = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      f_eff     = (freq_ff == '0) ? FreqW'(1) : freq_ff;
      half      = p_ff >> 1;
      tri_x     = (ph_ff > half) ? p_ff - ph_ff : ph_ff;
      k_val     = rem_rsp.rem[StepW-1:0];
      k_neg     = (k_val > StepW'(SineLast));
      mag       = SineTab[idx_ff];
      raw_wide  = (shape_ff == SHAPE_TRIANGLE) ? {mul_rsp.result, 1'b0}
                                               : {1'b0, mul_rsp.result};
      step_next = (step_ff == StepW'(Steps - 1)) ? '0 : step_ff + 1'b1;

      state_in     = state_ff;
      step_in      = step_ff;
      ph_in        = ph_ff;
      p_in         = p_ff;
      gain_in      = gain_ff;
      raw_in       = raw_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      sine_in      = sine_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sample_in    = sample_ff;
      cstart_in    = cstart_ff;
      load         = 1'b0;
      mul_req      = '{start: 1'b0, divide: 1'b0, a: '0, b: '0};
      rem_req      = '{start: 1'b0, num: '0, den: '0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               gain_in       = req_chan.gain;
               p_in          = PeriodTab[freq_ff];
               rem_req.start = 1'b1;
               rem_req.num   = NumW'(step_ff);
               rem_req.den   = PeriodTab[freq_ff];
               state_in      = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (rem_rsp.done) begin
               ph_in    = rem_rsp.rem[StepW-1:0];
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            case (shape_ff)
               SHAPE_SINE: begin
                  mul_req  = '{start: 1'b1, divide: 1'b0,
                               a: DataW'(step_ff), b: DataW'(f_eff)};
                  state_in = ST_KMUL;
               end
               SHAPE_SQUARE: begin
                  raw_in   = (ph_ff < half) ? amp_ff : '0;
                  state_in = ST_SCALE;
               end
               SHAPE_SAW: begin
                  mul_req  = '{start: 1'b1, divide: 1'b0,
                               a: DataW'(ph_ff), b: DataW'(f_eff)};
                  state_in = ST_M1;
               end
               default: begin
                  mul_req  = '{start: 1'b1, divide: 1'b0,
                               a: DataW'(tri_x), b: DataW'(f_eff)};
                  state_in = ST_M1;
               end
            endcase
         end
         ST_KMUL: begin
            if (mul_rsp.done) begin
               rem_req.start = 1'b1;
               rem_req.num   = mul_rsp.result[NumW-1:0];
               rem_req.den   = StepW'(Steps);
               state_in      = ST_KREM;
            end
         end
         ST_KREM: begin
            if (rem_rsp.done) begin
               neg_in   = k_neg;
               idx_in   = k_neg ? SineIdxW'(StepW'(Steps) - k_val) : SineIdxW'(k_val);
               state_in = ST_LUT;
            end
         end
         ST_LUT: begin
            sine_in  = neg_ff ? MidCode - DataW'(mag) : MidCode + DataW'(mag);
            state_in = ST_SINE;
         end
         ST_SINE: begin
            mul_req  = '{start: 1'b1, divide: 1'b1, a: sine_ff, b: amp_ff};
            state_in = ST_RAW;
         end
         ST_M1: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, divide: 1'b0,
                            a: mul_rsp.result[DataW-1:0], b: DataW'(RampStep)};
               state_in = ST_M2;
            end
         end
         ST_M2: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, divide: 1'b1,
                            a: mul_rsp.result[DataW-1:0], b: amp_ff};
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            if (mul_rsp.done) begin
               raw_in   = (raw_wide > (DataW + 2)'(MaxCode)) ? DataW'(MaxCode)
                                                             : raw_wide[DataW-1:0];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mul_req  = '{start: 1'b1, divide: 1'b1, a: raw_ff, b: gain_ff};
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (mul_rsp.done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               sample_in    = mul_rsp.result[DataW-1:0];
               cstart_in    = (ph_ff == '0);
               step_in      = step_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shape_ff     <= ShapeReset;
         freq_ff      <= FreqReset;
         amp_ff       <= AmpReset;
         step_ff      <= '0;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shape_ff     <= shape_in;
         freq_ff      <= freq_in;
         amp_ff       <= amp_in;
         step_ff      <= step_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      gain_ff   <= gain_in;
      raw_ff    <= raw_in;
      idx_ff    <= idx_in;
      neg_ff    <= neg_in;
      sine_ff   <= sine_in;
      sample_ff <= sample_in;
      cstart_ff <= cstart_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < StepW'(Steps))
      else $error("step counter left the frame");

   a_phase_in_period: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB |-> ph_ff < p_ff)
      else $error("phase not below period at writeback");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && rem_rsp.done))
      else $error("multiplier and remainder unit finished together");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      load |=> step_ff == (($past(step_ff) == StepW'(Steps - 1)) ? '0
                                                               : $past(step_ff) + 1'b1))
      else $error("step counter did not advance on writeback");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_KMUL || state_ff == ST_M1 || state_ff == ST_M2
                        || state_ff == ST_RAW || state_ff == ST_GAIN))
      else $error("multiplier result arrived outside a waiting state");

endmodule
